/* src/gmdvc_pkg.sv */
`timescale 1ns / 1ps

package gmdvc_pkg;

    // Store geometry
    localparam int NUM_V   = 1024;
    localparam int NUM_E   = 8192;
    localparam int VTX_W   = 10;
    localparam int ENT_W   = 13;
    localparam int DEG_W   = 14;
    localparam int FILL_W  = 14;
    localparam int CNT_W   = 11;
    localparam int EDGE_W  = 13;
    localparam int CFG_W   = 13;
    localparam logic [DEG_W-1:0] DEG_MAX = {DEG_W{1'b1}};

    // Item kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_STUCK = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Configuration register indexes
    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_EDGE_COUNT   = 1'b1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [VTX_W-1:0] owner_vertex;
        logic [VTX_W-1:0] neighbor_vertex;
    } item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             in_cover;
        logic [CNT_W-1:0] cover_size;
    } result_t;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_ADD_RD, S_ADD_WR, S_QRY_RD, S_QRY_FIN, S_CLR,
        S_COPY_RD, S_COPY_WR, S_CHECK, S_SCAN_RD, S_SCAN_CMP, S_COVER,
        S_HEAD, S_WALK_RD, S_WALK_NB, S_WALK_UPD, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_INIT_STEP, OP_CLR_STEP, OP_ADD_RD, OP_ADD_WR,
        OP_QRY_RD, OP_QRY_FIN, OP_COPY_RD, OP_COPY_WR, OP_SCAN_INIT,
        OP_SCAN_RD, OP_SCAN_CMP, OP_STUCK, OP_COVER, OP_HEAD, OP_WALK_RD,
        OP_WALK_NB, OP_WALK_UPD
    } dp_op_t;

    typedef struct packed {
        logic sweep_last;
        logic store_full;
        logic rem_zero;
        logic scan_last;
        logic found;
        logic head_valid;
        logic more;
    } dp_status_t;

endpackage

/* src/gmdvc_ctrl.sv */
`timescale 1ns / 1ps

module gmdvc_ctrl
    import gmdvc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] kind,
    input  dp_status_t st,
    output dp_op_t     op,
    output logic       busy,
    output logic       done
);

    state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence the datapath
    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                op = OP_INIT_STEP;
                if (st.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    op = OP_LATCH;
                    case (kind)
                        KIND_ADD:   state_next = S_ADD_RD;
                        KIND_RUN:   state_next = S_COPY_RD;
                        KIND_QUERY: state_next = S_QRY_RD;
                        default:    state_next = S_CLR;
                    endcase
                end
            end
            S_CLR:
            begin
                op = OP_CLR_STEP;
                if (st.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_ADD_RD:
            begin
                op         = OP_ADD_RD;
                state_next = st.store_full ? S_DONE : S_ADD_WR;
            end
            S_ADD_WR:
            begin
                op         = OP_ADD_WR;
                state_next = S_DONE;
            end
            S_QRY_RD:
            begin
                op         = OP_QRY_RD;
                state_next = S_QRY_FIN;
            end
            S_QRY_FIN:
            begin
                op         = OP_QRY_FIN;
                state_next = S_DONE;
            end
            S_COPY_RD:
            begin
                op         = OP_COPY_RD;
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                op         = OP_COPY_WR;
                state_next = st.sweep_last ? S_CHECK : S_COPY_RD;
            end
            S_CHECK:
            begin
                op         = OP_SCAN_INIT;
                state_next = st.rem_zero ? S_DONE : S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                op         = OP_SCAN_RD;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                op         = OP_SCAN_CMP;
                state_next = st.scan_last ? S_COVER : S_SCAN_RD;
            end
            S_COVER:
            begin
                if (st.found)
                begin
                    op         = OP_COVER;
                    state_next = S_HEAD;
                end
                else
                begin
                    op         = OP_STUCK;
                    state_next = S_DONE;
                end
            end
            S_HEAD:
            begin
                op         = OP_HEAD;
                state_next = st.head_valid ? S_WALK_RD : S_CHECK;
            end
            S_WALK_RD:
            begin
                op         = OP_WALK_RD;
                state_next = S_WALK_NB;
            end
            S_WALK_NB:
            begin
                op         = OP_WALK_NB;
                state_next = S_WALK_UPD;
            end
            S_WALK_UPD:
            begin
                op         = OP_WALK_UPD;
                state_next = st.more ? S_WALK_RD : S_CHECK;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/gmdvc_dp.sv */
`timescale 1ns / 1ps

module gmdvc_dp
    import gmdvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_op_t           op,
    input  item_t            item,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output dp_status_t       st,
    output result_t          result
);

    localparam logic [CNT_W-1:0] NUM_V_C = CNT_W'(NUM_V);

    // Graph and run stores
    logic [DEG_W-1:0] head_mem [NUM_V];
    logic [DEG_W-1:0] base_mem [NUM_V];
    logic [DEG_W-1:0] work_mem [NUM_V];
    logic             cov_mem  [NUM_V];
    logic [DEG_W-1:0] next_mem [NUM_E];
    logic [VTX_W-1:0] nb_mem   [NUM_E];

    logic [DEG_W-1:0] head_rd, base_rd, work_rd, next_rd;
    logic             cov_rd;
    logic [VTX_W-1:0] nb_rd;

    logic [CNT_W-1:0]  vcount_reg;
    logic [EDGE_W-1:0] ecount_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [EDGE_W-1:0] remaining_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [VTX_W-1:0]  idx_reg;
    logic [VTX_W-1:0]  best_reg;
    logic [DEG_W-1:0]  best_deg_reg;
    logic [ENT_W-1:0]  entry_reg, next_reg;
    logic              more_reg;
    logic [VTX_W-1:0]  u_reg;
    item_t             item_reg;
    logic [1:0]        status_reg;
    logic              bit_reg;

    logic [CNT_W-1:0] n_act;
    logic             scan_in;
    logic             u_live;
    logic             qry_oor;

    // Active vertex bound of a run
    assign n_act   = (vcount_reg > NUM_V_C) ? NUM_V_C : vcount_reg;
    assign scan_in = (CNT_W'(idx_reg) < n_act);
    assign u_live  = (CNT_W'(u_reg) < n_act) && !cov_rd;
    assign qry_oor = (CNT_W'(item_reg.owner_vertex) >= vcount_reg);

    always_comb
    begin
        st.sweep_last = (idx_reg == {VTX_W{1'b1}});
        st.store_full = (fill_reg >= FILL_W'(NUM_E));
        st.rem_zero   = (remaining_reg == '0);
        st.scan_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) >= n_act);
        st.found      = (best_deg_reg != '0);
        st.head_valid = head_rd[DEG_W-1];
        st.more       = more_reg;
    end

    assign result.status     = status_reg;
    assign result.in_cover   = bit_reg;
    assign result.cover_size = total_reg;

    // Head table: read for add and cover, write on add and clear
    always_ff @(posedge clk)
    begin
        case (op)
            OP_ADD_RD: head_rd <= head_mem[item_reg.owner_vertex];
            OP_COVER:  head_rd <= head_mem[best_reg];
            default:   head_rd <= head_rd;
        endcase
        if (op == OP_ADD_WR)
        begin
            head_mem[item_reg.owner_vertex] <= {1'b1, fill_reg[ENT_W-1:0]};
        end
        else if (op == OP_INIT_STEP || op == OP_CLR_STEP)
        begin
            head_mem[idx_reg] <= '0;
        end
    end

    // Base degrees: read for add and copy, write on add and clear
    always_ff @(posedge clk)
    begin
        base_rd <= (op == OP_COPY_RD) ? base_mem[idx_reg] : base_mem[item_reg.owner_vertex];
        if (op == OP_ADD_WR)
        begin
            base_mem[item_reg.owner_vertex] <= (base_rd == DEG_MAX) ? base_rd
                                                                    : base_rd + DEG_W'(1);
        end
        else if (op == OP_INIT_STEP || op == OP_CLR_STEP)
        begin
            base_mem[idx_reg] <= '0;
        end
    end

    // Working degrees: read for scan and walk, write on copy and walk
    always_ff @(posedge clk)
    begin
        work_rd <= (op == OP_WALK_NB) ? work_mem[nb_rd] : work_mem[idx_reg];
        if (op == OP_COPY_WR)
        begin
            work_mem[idx_reg] <= base_rd;
        end
        else if (op == OP_WALK_UPD && u_live && work_rd != '0)
        begin
            work_mem[u_reg] <= work_rd - DEG_W'(1);
        end
    end

    // Cover bits
    always_ff @(posedge clk)
    begin
        case (op)
            OP_WALK_NB: cov_rd <= cov_mem[nb_rd];
            OP_QRY_RD:  cov_rd <= cov_mem[item_reg.owner_vertex];
            default:    cov_rd <= cov_mem[idx_reg];
        endcase
        if (op == OP_COVER)
        begin
            cov_mem[best_reg] <= 1'b1;
        end
        else if (op == OP_INIT_STEP || op == OP_COPY_WR)
        begin
            cov_mem[idx_reg] <= 1'b0;
        end
    end

    // Entry chains
    always_ff @(posedge clk)
    begin
        next_rd <= next_mem[entry_reg];
        nb_rd   <= nb_mem[entry_reg];
        if (op == OP_ADD_WR)
        begin
            next_mem[fill_reg[ENT_W-1:0]] <= head_rd;
            nb_mem[fill_reg[ENT_W-1:0]]   <= item_reg.neighbor_vertex;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= NUM_V_C;
            ecount_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VERTEX_COUNT: vcount_reg <= cfg_data[CNT_W-1:0];
                CFG_EDGE_COUNT:   ecount_reg <= cfg_data[EDGE_W-1:0];
                default:          ecount_reg <= ecount_reg;
            endcase
        end
    end

    // Counters and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            remaining_reg <= '0;
            best_deg_reg  <= '0;
            status_reg    <= ST_OK;
            bit_reg       <= 1'b0;
        end
        else
        begin
            case (op)
                OP_LATCH:
                begin
                    idx_reg    <= '0;
                    status_reg <= ST_OK;
                    bit_reg    <= 1'b0;
                    if (item.kind == KIND_RUN)
                    begin
                        remaining_reg <= ecount_reg;
                        total_reg     <= '0;
                    end
                end
                OP_INIT_STEP:
                begin
                    idx_reg <= idx_reg + VTX_W'(1);
                end
                OP_CLR_STEP:
                begin
                    idx_reg  <= idx_reg + VTX_W'(1);
                    fill_reg <= '0;
                end
                OP_ADD_RD:
                begin
                    if (st.store_full)
                    begin
                        status_reg <= ST_FULL;
                    end
                end
                OP_ADD_WR:
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
                OP_QRY_FIN:
                begin
                    status_reg <= qry_oor ? ST_RANGE : ST_OK;
                    bit_reg    <= qry_oor ? 1'b0 : cov_rd;
                end
                OP_COPY_WR:
                begin
                    idx_reg <= idx_reg + VTX_W'(1);
                end
                OP_SCAN_INIT:
                begin
                    idx_reg      <= '0;
                    best_deg_reg <= '0;
                end
                OP_SCAN_CMP:
                begin
                    idx_reg <= idx_reg + VTX_W'(1);
                    if (scan_in && !cov_rd && work_rd > best_deg_reg)
                    begin
                        best_deg_reg <= work_rd;
                    end
                end
                OP_STUCK:
                begin
                    status_reg <= ST_STUCK;
                end
                OP_COVER:
                begin
                    total_reg <= total_reg + CNT_W'(1);
                end
                OP_WALK_UPD:
                begin
                    if (u_live && remaining_reg != '0)
                    begin
                        remaining_reg <= remaining_reg - EDGE_W'(1);
                    end
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // Item, best vertex and chain walk registers
    always_ff @(posedge clk)
    begin
        if (op == OP_LATCH)
        begin
            item_reg <= item;
        end
        if (op == OP_SCAN_CMP && scan_in && !cov_rd && work_rd > best_deg_reg)
        begin
            best_reg <= idx_reg;
        end
        if (op == OP_HEAD)
        begin
            entry_reg <= head_rd[ENT_W-1:0];
        end
        else if (op == OP_WALK_UPD)
        begin
            entry_reg <= next_reg;
        end
        if (op == OP_WALK_NB)
        begin
            u_reg    <= nb_rd;
            next_reg <= next_rd[ENT_W-1:0];
            more_reg <= next_rd[DEG_W-1];
        end
    end

endmodule

/* src/greedy_max_degree_vertex_cover_core.sv */
// An add reads the head and degree, then writes the entry unless the store is full;
// a query reads the cover bit; a clear sweeps every vertex. A run copies degrees, then
// per round checks, scans the vertices and walks the chosen vertex's chain, then ends.
// Throughput: one transaction at a time; busy drops the cycle after the done strobe.
// Reset: asynchronous, active low; a clearing pass follows with busy high.
// Results show for one cycle under done; the receiver cannot stall.
`timescale 1ns / 1ps

module greedy_max_degree_vertex_cover_core
    import gmdvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    output logic             done,
    output result_t          result,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    dp_op_t     op;
    dp_status_t st;

    // Sequence each transaction
    gmdvc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (item.kind),
        .st    (st),
        .op    (op),
        .busy  (busy),
        .done  (done)
    );

    // Hold the graph and do the arithmetic
    gmdvc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .st        (st),
        .result    (result)
    );

endmodule

/* src/gmdvc_checker.sv */
`timescale 1ns / 1ps

module gmdvc_checker
    import gmdvc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // Go busy after an accepted transaction
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // Strobe only while busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside busy");

    // Single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // Cover bit only on a clean result
    a_bit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.in_cover |-> result.status == ST_OK)
        else $error("cover bit with error status");

    // Cover size bounded by vertex store
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.cover_size <= CNT_W'(NUM_V))
        else $error("cover size too large");

endmodule

bind greedy_max_degree_vertex_cover_core gmdvc_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

/* tb/greedy_max_degree_vertex_cover_core_tb.sv */
`timescale 1ns / 1ps

module greedy_max_degree_vertex_cover_core_tb;
    import gmdvc_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    item_t            item;
    logic             done;
    result_t          result;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    greedy_max_degree_vertex_cover_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the graph store and the cover
    int      chain_head [NUM_V];
    int      chain_next [NUM_E];
    int      chain_nbr  [NUM_E];
    int      fill_level;
    int      base_deg   [NUM_V];
    int      work_deg   [NUM_V];
    bit      cov_bit    [NUM_V];
    int      cov_total;
    int      vtx_limit;
    int      edges_to_cover;

    item_t   pending_items [$];
    result_t cover_results [$];
    int      error_count;
    int      items_queued;
    int      gap_left;
    bit      no_idle;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void reset_mirror();
        for (int v = 0; v < NUM_V; v++)
        begin
            chain_head[v] = -1;
            base_deg[v]   = 0;
            work_deg[v]   = 0;
            cov_bit[v]    = 0;
        end
        fill_level     = 0;
        cov_total      = 0;
        vtx_limit      = 1024;
        edges_to_cover = 0;
    endfunction

    // Greedy cover over the mirrored store; returns the status of the run
    function automatic logic [1:0] cover_graph();
        int n;
        int left;
        int best;
        int best_deg;
        int e;
        int u;
        int steps;
        n    = (vtx_limit < NUM_V) ? vtx_limit : NUM_V;
        left = edges_to_cover;
        for (int v = 0; v < NUM_V; v++)
        begin
            cov_bit[v]  = 0;
            work_deg[v] = base_deg[v];
        end
        cov_total = 0;
        while (left > 0)
        begin
            best     = n;
            best_deg = 0;
            for (int v = 0; v < n; v++)
            begin
                if (!cov_bit[v] && work_deg[v] > best_deg)
                begin
                    best_deg = work_deg[v];
                    best     = v;
                end
            end
            if (best >= n)
                return ST_STUCK;
            cov_bit[best] = 1;
            cov_total++;
            e     = chain_head[best];
            steps = 0;
            while (e >= 0 && steps < NUM_E)
            begin
                u = chain_nbr[e];
                if (u < n && !cov_bit[u])
                begin
                    if (left > 0)
                        left--;
                    if (work_deg[u] > 0)
                        work_deg[u]--;
                end
                e = chain_next[e];
                steps++;
            end
        end
        return ST_OK;
    endfunction

    // Apply one transaction to the mirror and return its result
    function automatic result_t apply_item(input item_t it);
        result_t r;
        r = '0;
        case (it.kind)
            KIND_ADD:
            begin
                if (fill_level >= NUM_E)
                    r.status = ST_FULL;
                else
                begin
                    chain_nbr[fill_level]  = it.neighbor_vertex;
                    chain_next[fill_level] = chain_head[it.owner_vertex];
                    chain_head[it.owner_vertex] = fill_level;
                    fill_level++;
                    if (base_deg[it.owner_vertex] < int'(DEG_MAX))
                        base_deg[it.owner_vertex]++;
                    r.status = ST_OK;
                end
            end
            KIND_RUN:
                r.status = cover_graph();
            KIND_QUERY:
            begin
                if (it.owner_vertex >= vtx_limit)
                    r.status = ST_RANGE;
                else
                    r.in_cover = cov_bit[it.owner_vertex];
            end
            default:
            begin
                for (int v = 0; v < NUM_V; v++)
                begin
                    chain_head[v] = -1;
                    base_deg[v]   = 0;
                end
                fill_level = 0;
            end
        endcase
        r.cover_size = cov_total[CNT_W-1:0];
        return r;
    endfunction

    // Driver: present queued items with random gaps, or back to back when no_idle is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            item     <= '0;
            gap_left <= 0;
        end
        else if (start && !busy)
        begin
            cover_results = {cover_results, apply_item(item)};
            if (no_idle && pending_items.size() > 0)
            begin
                item  <= pending_items.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start    <= 1'b0;
                gap_left <= no_idle ? 0 : $urandom_range(0, 4);
            end
        end
        else if (!start)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_items.size() > 0)
            begin
                item  <= pending_items.pop_front();
                start <= 1'b1;
            end
        end
    end

    // Monitor: check each result against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (cover_results.size() == 0)
            begin
                report_mismatch("unexpected results", 1, 0);
            end
            else
            begin
                want = cover_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", result.status, want.status);
                if (result.in_cover !== want.in_cover)
                    report_mismatch("in_cover", result.in_cover, want.in_cover);
                if (result.cover_size !== want.cover_size)
                    report_mismatch("cover_size", result.cover_size, want.cover_size);
            end
        end
    end

    task automatic send(input logic [1:0] k, input int o, input int nb);
        item_t it;
        it.kind            = k;
        it.owner_vertex    = o[VTX_W-1:0];
        it.neighbor_vertex = nb[VTX_W-1:0];
        pending_items = {pending_items, it};
        items_queued++;
    endtask

    // Check for quiet at the falling edge, then return on a rising edge
    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() > 0 || start || cover_results.size() > 0 || busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_VERTEX_COUNT)
            vtx_limit = value;
        else
            edges_to_cover = value;
    endtask

    // Random undirected graph on span vertices, most edges stored both ways
    task automatic add_graph(input int span, input int edges);
        int a;
        int b;
        for (int i = 0; i < edges; i++)
        begin
            a = $urandom_range(0, span - 1);
            b = $urandom_range(0, span - 1);
            send(KIND_ADD, a, b);
            if ($urandom_range(0, 9) != 0)
                send(KIND_ADD, b, a);
        end
    endtask

    initial
    begin
        int vc;
        int ne;
        int ec;
        error_count  = 0;
        items_queued = 0;
        no_idle      = 0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_VERTEX_COUNT;
        cfg_data     = '0;
        reset_mirror();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset state, empty run, extreme vertices, full range
        send(KIND_QUERY, 0, 0);
        send(KIND_QUERY, 1023, 0);
        send(KIND_RUN, 0, 0);
        send(KIND_ADD, 0, 1023);
        send(KIND_ADD, 1023, 0);
        send(KIND_ADD, 0, 1);
        send(KIND_ADD, 1, 0);
        send(KIND_ADD, 682, 341);
        send(KIND_ADD, 341, 682);
        write_reg(CFG_EDGE_COUNT, 3);
        send(KIND_RUN, 0, 0);
        send(KIND_QUERY, 0, 0);
        send(KIND_QUERY, 1023, 0);
        send(KIND_QUERY, 341, 0);
        // Neighbors above the vertex bound are skipped; remaining edges stall
        write_reg(CFG_VERTEX_COUNT, 2);
        send(KIND_RUN, 0, 0);
        send(KIND_QUERY, 1, 0);
        send(KIND_QUERY, 2, 0);
        send(KIND_QUERY, 1023, 0);
        write_reg(CFG_VERTEX_COUNT, 1);
        write_reg(CFG_EDGE_COUNT, 4096);
        send(KIND_RUN, 0, 0);
        send(KIND_QUERY, 0, 0);
        send(KIND_CLEAR, 0, 0);
        send(KIND_RUN, 0, 0);
        send(KIND_QUERY, 0, 0);

        // Random phases: build a graph, cover it, probe the cover bits
        while (items_queued < 550)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
                vc = 1024;
            else if ($urandom_range(0, 9) == 0)
                vc = 1;
            else
                vc = $urandom_range(2, 40);
            write_reg(CFG_VERTEX_COUNT, vc);
            if ($urandom_range(0, 3) != 0)
                send(KIND_CLEAR, 0, 0);
            ne = (vc == 1024) ? $urandom_range(1, 6) : $urandom_range(1, 12);
            add_graph((vc == 1024) ? 1024 : vc + $urandom_range(0, 3), ne);
            // Noise entries anywhere in the vertex space
            for (int i = $urandom_range(0, 2); i > 0; i--)
                send(KIND_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023));
            case ($urandom_range(0, 5))
                0:       ec = 0;
                1:       ec = ne + $urandom_range(1, 8);
                2:       ec = $urandom_range(0, ne);
                3:       ec = (vc == 1024) ? ne : 8191;
                default: ec = ne;
            endcase
            write_reg(CFG_EDGE_COUNT, ec);
            send(KIND_RUN, 0, 0);
            for (int i = $urandom_range(2, 8); i > 0; i--)
                send(KIND_QUERY, $urandom_range(0, vc + 2), 0);
            send(KIND_QUERY, $urandom_range(0, 1023), 0);
        end

        // Close with a probe, a clear and a fresh entry
        no_idle = 1;
        send(KIND_QUERY, 5, 0);
        send(KIND_CLEAR, 0, 0);
        send(KIND_ADD, 3, 4);

        wait_idle();
        no_idle = 0;
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("greedy_max_degree_vertex_cover_core_tb: clean");
        else
            $display("greedy_max_degree_vertex_cover_core_tb: errors");
        $finish;
    end

    initial
    begin
        #80ms;
        $display("greedy_max_degree_vertex_cover_core_tb: errors");
        $finish;
    end

endmodule
